### rtl/fxalu_pkg.sv
package fxalu_pkg;

  localparam int FRACT_BITS = 8;
  localparam int WORD_BITS  = 32;
  localparam int DIV_W      = WORD_BITS + FRACT_BITS;
  localparam int DIV_STEPS  = 8;
  localparam int DIV_BPS    = (DIV_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_PAD    = DIV_BPS * DIV_STEPS;

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_LT   = 4'd4,
    CMD_LE   = 4'd5,
    CMD_GT   = 4'd6,
    CMD_GE   = 4'd7,
    CMD_EQ   = 4'd8,
    CMD_NE   = 4'd9,
    CMD_MIN  = 4'd10,
    CMD_MAX  = 4'd11,
    CMD_INC  = 4'd12,
    CMD_DEC  = 4'd13,
    CMD_FROM = 4'd14,
    CMD_TO   = 4'd15
  } cmd_t;

endpackage

### rtl/fixed_point_alu_top.sv
// Signed Q24.8 fixed-point ALU. Fully pipelined: a new beat is taken every cycle unless
// a stalled valid output holds the pipe. The pipe holds ten register stages (operand
// decode, multiply alongside the first of eight restoring divide stages that each resolve
// five quotient bits, seven more divide stages, output register). Every command runs
// through all stages so results leave in order. Divide truncates toward zero; a zero
// divisor gives a zero result with divide_by_zero set. All results wrap to the word width.
// A stall on a valid output freezes the whole pipe.
module fixed_point_alu_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_command,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_result,
  output logic        out_compare_true,
  output logic        out_divide_by_zero
);

  localparam int W  = fxalu_pkg::WORD_BITS;
  localparam int F  = fxalu_pkg::FRACT_BITS;
  localparam int NS = fxalu_pkg::DIV_STEPS;
  localparam int BS = fxalu_pkg::DIV_BPS;
  localparam int PW = fxalu_pkg::DIV_PAD;
  localparam int NST = NS + 2;

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 0: decode
  logic signed [W-1:0] a_w, b_w;
  assign a_w = in_operand_a[W-1:0];
  assign b_w = in_operand_b[W-1:0];

  logic [NST-1:0]      vld_r;
  fxalu_pkg::cmd_t     cmd_r  [NST];
  logic signed [W-1:0] res_r  [NST];
  logic                cmp_r  [NST];
  logic                neg_r  [NST];
  logic                dz_r   [NST];
  logic [PW-1:0]       quo_r  [NST];
  logic [W:0]          rem_r  [NST];
  logic [W-1:0]        dvs_r  [NST];

  logic signed [W-1:0] a_r, b_r;

  // combinational stage 0 results for simple commands
  logic signed [W-1:0] simple_res;
  logic                simple_cmp;
  logic                lt, eq;
  logic [W-1:0]        abs_a, abs_b;

  always_comb begin
    lt = a_w < b_w;
    eq = a_w == b_w;
    simple_res = '0;
    simple_cmp = 1'b0;
    case (fxalu_pkg::cmd_t'(in_command))
      fxalu_pkg::CMD_ADD:  simple_res = a_w + b_w;
      fxalu_pkg::CMD_SUB:  simple_res = a_w - b_w;
      fxalu_pkg::CMD_LT:   simple_cmp = lt;
      fxalu_pkg::CMD_LE:   simple_cmp = lt || eq;
      fxalu_pkg::CMD_GT:   simple_cmp = !(lt || eq);
      fxalu_pkg::CMD_GE:   simple_cmp = !lt;
      fxalu_pkg::CMD_EQ:   simple_cmp = eq;
      fxalu_pkg::CMD_NE:   simple_cmp = !eq;
      fxalu_pkg::CMD_MIN:  simple_res = lt ? a_w : b_w;
      fxalu_pkg::CMD_MAX:  simple_res = (!(lt || eq)) ? a_w : b_w;
      fxalu_pkg::CMD_INC:  simple_res = a_w + W'(1);
      fxalu_pkg::CMD_DEC:  simple_res = a_w - W'(1);
      fxalu_pkg::CMD_FROM: simple_res = a_w <<< F;
      fxalu_pkg::CMD_TO:   simple_res = a_w >>> F;
      default:             simple_res = '0;
    endcase
    abs_a = a_w[W-1] ? W'(-a_w) : a_w;
    abs_b = b_w[W-1] ? W'(-b_w) : b_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r[0] <= fxalu_pkg::cmd_t'(in_command);
      res_r[0] <= simple_res;
      cmp_r[0] <= simple_cmp;
      neg_r[0] <= a_w[W-1] ^ b_w[W-1];
      dz_r[0]  <= (in_command == fxalu_pkg::CMD_DIV) && (b_w == '0);
      quo_r[0] <= PW'({abs_a, F'(0)});
      rem_r[0] <= '0;
      dvs_r[0] <= abs_b;
      a_r      <= a_w;
      b_r      <= b_w;
    end
  end

  // stage 1: multiply, and first divide stage
  logic signed [2*W-1:0] prod;
  assign prod = a_r * b_r;

  // divide stages: restoring, BS bits per stage
  logic [PW-1:0] q_nxt [NS];
  logic [W:0]    r_nxt [NS];

  for (genvar s = 0; s < NS; s++) begin : g_div
    always_comb begin
      logic [W:0]    r;
      logic [PW-1:0] q;
      logic [W+1:0]  t;
      r = rem_r[s];
      q = quo_r[s];
      for (int i = 0; i < BS; i++) begin
        t = {r, q[PW-1]};
        q = {q[PW-2:0], 1'b0};
        if (t >= {2'b00, dvs_r[s]}) begin
          r = (W+1)'(t - {2'b00, dvs_r[s]});
          q[0] = 1'b1;
        end else begin
          r = t[W:0];
        end
      end
      q_nxt[s] = q;
      r_nxt[s] = r;
    end
  end

  for (genvar s = 1; s <= NS; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        cmd_r[s] <= cmd_r[s-1];
        cmp_r[s] <= cmp_r[s-1];
        neg_r[s] <= neg_r[s-1];
        dz_r[s]  <= dz_r[s-1];
        quo_r[s] <= q_nxt[s-1];
        rem_r[s] <= r_nxt[s-1];
        dvs_r[s] <= dvs_r[s-1];
        if (s == 1 && cmd_r[s-1] == fxalu_pkg::CMD_MUL) begin
          res_r[s] <= prod[F +: W];
        end else begin
          res_r[s] <= res_r[s-1];
        end
      end
    end
  end

  // final: sign fix for divide
  logic [W-1:0] q_mag;
  logic signed [W-1:0] div_res;
  assign q_mag = quo_r[NS][W-1:0];
  assign div_res = dz_r[NS] ? '0 : (neg_r[NS] ? W'(-q_mag) : q_mag);

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r[NS+1] <= (cmd_r[NS] == fxalu_pkg::CMD_DIV) ? div_res : res_r[NS];
      cmp_r[NS+1] <= cmp_r[NS];
      dz_r[NS+1]  <= dz_r[NS];
      cmd_r[NS+1] <= cmd_r[NS];
    end
  end

  assign out_valid          = vld_r[NST-1];
  assign out_result         = 32'(res_r[NST-1]);
  assign out_compare_true   = cmp_r[NST-1];
  assign out_divide_by_zero = dz_r[NST-1];

`ifndef SYNTHESIS
  a_dz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> cmd_r[NST-1] == fxalu_pkg::CMD_DIV && out_result == '0)
    else $error("divide_by_zero on non-divide or nonzero result");
  a_cmp_res_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_result == '0)
    else $error("compare with nonzero result");
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld_r))
    else $error("pipe moved during stall");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##0 (!out_stall) [*NST] |=> out_valid)
    else $error("beat lost in pipe");
`endif

endmodule
